>>> sv/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, idle while reset is held
`define SCT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define SCT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/sct_pkg.sv
// shared types and constants of the sparse coordinate table
package sct_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 1024;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int INDEX_W       = 10;
    localparam int VALUE_W       = 32;
    localparam int DIM_W         = 11;
    localparam int APB_ADDR_W    = 3;

    // reset value of the dimension registers
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

    // operation codes
    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_GET = 2'd1;
    localparam logic [1:0] OP_ACC = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // register index, taken from paddr bit 2
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // one stored entry
    typedef struct packed {
        logic [INDEX_W-1:0]        row;
        logic [INDEX_W-1:0]        col;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    // request from the sequencer to the entry memory
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    // one result item
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic [1:0]                status;
    } result_t;

endpackage

>>> sv/sct_entry_mem.sv
// entry store: one write port, one read port with registered read data
module sct_entry_mem (
    input  logic              aclk,
    input  sct_pkg::mem_req_t req,
    output sct_pkg::entry_t   rdata
);
    import sct_pkg::*;

    entry_t entries_reg [TABLE_ENTRIES];
    entry_t rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            entries_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rdata_reg <= entries_reg[req.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sct_scan_seq.sv
// sequencer: range check, linear scan with one shared comparator, update and append
module sct_scan_seq (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         in_op,
    input  logic [sct_pkg::INDEX_W-1:0]        in_row,
    input  logic [sct_pkg::INDEX_W-1:0]        in_col,
    input  logic signed [sct_pkg::VALUE_W-1:0] in_value,
    input  logic [sct_pkg::DIM_W-1:0]          row_count,
    input  logic [sct_pkg::DIM_W-1:0]          column_count,
    output sct_pkg::mem_req_t                  mem_req,
    input  sct_pkg::entry_t                    mem_rdata,
    output logic                               res_valid,
    input  logic                               res_ready,
    output sct_pkg::result_t                   res
);
    import sct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_RESP
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               pend_reg, pend_next;

    logic [1:0]                op_reg, op_next;
    logic [INDEX_W-1:0]        key_row_reg, key_row_next;
    logic [INDEX_W-1:0]        key_col_reg, key_col_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [ADDR_W-1:0]         pend_idx_reg, pend_idx_next;
    logic [ADDR_W-1:0]         hit_idx_reg, hit_idx_next;
    logic signed [VALUE_W-1:0] hit_val_reg, hit_val_next;
    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    logic [1:0]                res_status_reg, res_status_next;

    logic in_range;
    logic key_match;

    // coordinate check against the configured dimensions
    assign in_range = ({1'b0, in_row} < row_count) && ({1'b0, in_col} < column_count);

    // shared comparator on the registered read data
    assign key_match = (mem_rdata.row == key_row_reg) && (mem_rdata.col == key_col_reg);

    // next state and memory requests
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        op_next         = op_reg;
        key_row_next    = key_row_reg;
        key_col_next    = key_col_reg;
        val_next        = val_reg;
        pend_idx_next   = pend_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_val_next    = hit_val_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        mem_req         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next        = in_op;
                    key_row_next   = in_row;
                    key_col_next   = in_col;
                    val_next       = in_value;
                    res_value_next = '0;
                    if (in_op == OP_NOP) begin
                        res_status_next = ST_OK;
                        state_next      = S_RESP;
                    end else if (!in_range) begin
                        res_status_next = ST_RANGE;
                        state_next      = S_RESP;
                    end else begin
                        ptr_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (pend_reg && key_match) begin
                    hit_idx_next = pend_idx_reg;
                    hit_val_next = mem_rdata.value;
                    pend_next    = 1'b0;
                    state_next   = S_HIT;
                end else if (ptr_reg < count_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg[ADDR_W-1:0];
                    pend_next       = 1'b1;
                    pend_idx_next   = ptr_reg[ADDR_W-1:0];
                    ptr_next        = ptr_reg + CNT_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_MISS;
                end
            end
            S_HIT: begin
                res_status_next       = ST_OK;
                mem_req.wr_addr       = hit_idx_reg;
                mem_req.wr_data.row   = key_row_reg;
                mem_req.wr_data.col   = key_col_reg;
                unique case (op_reg)
                    OP_GET: begin
                        res_value_next = hit_val_reg;
                    end
                    OP_SET: begin
                        mem_req.wr_en         = 1'b1;
                        mem_req.wr_data.value = val_reg;
                    end
                    OP_ACC: begin
                        mem_req.wr_en         = 1'b1;
                        mem_req.wr_data.value = hit_val_reg + val_reg;
                    end
                    default: begin
                    end
                endcase
                state_next = S_RESP;
            end
            S_MISS: begin
                mem_req.wr_addr       = count_reg[ADDR_W-1:0];
                mem_req.wr_data.row   = key_row_reg;
                mem_req.wr_data.col   = key_col_reg;
                mem_req.wr_data.value = val_reg;
                if (op_reg == OP_GET) begin
                    res_status_next = ST_MISSING;
                end else if (count_reg == CNT_W'(TABLE_ENTRIES)) begin
                    res_status_next = ST_FULL;
                end else begin
                    // append the new entry at the end of the list
                    mem_req.wr_en   = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = ST_OK;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, counters and the scan tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
        end
    end

    // item payload and result
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_row_reg    <= key_row_next;
        key_col_reg    <= key_col_next;
        val_reg        <= val_next;
        pend_idx_reg   <= pend_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_val_reg    <= hit_val_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign res_valid     = (state_reg == S_RESP);
    assign res.value_out = res_value_reg;
    assign res.status    = res_status_reg;

endmodule

>>> sv/sparse_coordinate_table.sv
// Sparse coordinate table top level: config registers, sequencer, entry memory, output register.
// A range error or no-op goes straight to the result; any other operation first runs the linear
// scan through the single memory read port, which reads the entries one by one up to entry_count.
// One transaction at a time; the next is taken the cycle after the result moves to the output register.
// Reset (aresetn low, synchronous) empties the table, sets both dimensions to 1024
// and drops m_axis_tvalid; memory contents are not cleared, entries past the count are never read.
module sparse_coordinate_table (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [55:0]                      s_axis_tdata,  // row_index, column_index, value_in, pad
    input  logic [1:0]                       s_axis_tuser,  // operation
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // value_out
    output logic [1:0]                       m_axis_tuser,  // status
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sct_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import sct_pkg::*;

    logic [DIM_W-1:0] row_count_reg, column_count_reg;
    logic             cfg_write;

    mem_req_t mem_req;
    entry_t   mem_rdata;
    result_t  res;
    logic     res_valid;
    logic     res_ready;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]  m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    // configuration writes
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= DIM_RESET;
            column_count_reg <= DIM_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_ROW_COUNT:    row_count_reg    <= pwdata[DIM_W-1:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // configuration reads
    always_comb begin
        unique case (paddr[2])
            REG_ROW_COUNT:    prdata = {{(32-DIM_W){1'b0}}, row_count_reg};
            REG_COLUMN_COUNT: prdata = {{(32-DIM_W){1'b0}}, column_count_reg};
            default:          prdata = '0;
        endcase
    end

    sct_scan_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_op        (s_axis_tuser),
        .in_row       (s_axis_tdata[9:0]),
        .in_col       (s_axis_tdata[19:10]),
        .in_value     (s_axis_tdata[51:20]),
        .row_count    (row_count_reg),
        .column_count (column_count_reg),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    sct_entry_mem u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // output register, refilled in the cycle it is drained
    assign res_ready = !m_tvalid_reg || m_axis_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= res.value_out;
            m_tuser_reg <= res.status;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule

>>> sv/sct_checker.sv
// port-level checker for the sparse coordinate table, with its bind
`include "assert_macros.svh"

module sct_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [55:0]                    s_axis_tdata,
    input logic [1:0]                     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [31:0]                    m_axis_tdata,
    input logic [1:0]                     m_axis_tuser,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [sct_pkg::APB_ADDR_W-1:0] paddr,
    input logic [31:0]                    pwdata,
    input logic [31:0]                    prdata,
    input logic                           pready
);
    import sct_pkg::*;

    // a stalled result holds its payload
    `SCT_ASSERT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "result payload changed while stalled")

    // one transaction at a time: busy right after an accepted item
    `SCT_ASSERT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken again before the scan ran")

    // a nonzero value only comes with a successful get
    `SCT_ASSERT(a_value_ok, aclk, aresetn, m_axis_tvalid && (m_axis_tdata != 32'd0) |-> m_axis_tuser == ST_OK, "nonzero value with an error status")

    // reset empties the output register
    `SCT_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_axis_tvalid, "result valid right after reset")

    // the configuration port never inserts wait states
    `SCT_ASSERT(a_pready, aclk, aresetn, psel && penable |-> pready, "config access stalled")

endmodule

bind sparse_coordinate_table sct_checker u_sct_checker (.*);

>>> sim/sct_result_checker.sv
// result checker for the sparse coordinate table: tracks the entry list and compares every result
module sct_result_checker
    import sct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream, observed
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [55:0]           s_axis_tdata,  // row_index, column_index, value_in, pad
    input  logic [1:0]            s_axis_tuser,  // operation
    // result stream, observed
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [31:0]           m_axis_tdata,  // value_out
    input  logic [1:0]            m_axis_tuser,  // status
    // configuration port, observed
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    // to the testbench top
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // local copy of the entry list and the dimension registers
    entry_t           stored_entries [TABLE_ENTRIES];
    int               stored_count;
    logic [DIM_W-1:0] row_limit;
    logic [DIM_W-1:0] col_limit;

    // results still owed by the block, oldest first
    result_t          pending_results [$];
    result_t          oldest;
    int               error_total;

    // apply one operation to the local entry list and return the result it yields
    function automatic result_t table_outcome(input logic [1:0] op,
                                              input logic [INDEX_W-1:0] row,
                                              input logic [INDEX_W-1:0] col,
                                              input logic signed [VALUE_W-1:0] value);
        result_t res;
        int      slot;
        res.value_out = '0;
        res.status    = ST_OK;
        if (op == OP_NOP) begin
            return res;
        end
        // range check comes before any lookup
        if (!({1'b0, row} < row_limit && {1'b0, col} < col_limit)) begin
            res.status = ST_RANGE;
            return res;
        end
        // lowest matching entry wins
        slot = stored_count;
        for (int k = stored_count - 1; k >= 0; k--) begin
            if (stored_entries[k].row == row && stored_entries[k].col == col) begin
                slot = k;
            end
        end
        case (op) inside
            OP_GET: begin
                if (slot < stored_count) begin
                    res.value_out = stored_entries[slot].value;
                end else begin
                    res.status = ST_MISSING;
                end
            end
            OP_SET, OP_ACC: begin
                if (slot < stored_count) begin
                    // update in place, wraps at the value width
                    if (op == OP_SET) begin
                        stored_entries[slot].value = value;
                    end else begin
                        stored_entries[slot].value = stored_entries[slot].value + value;
                    end
                end else if (stored_count >= TABLE_ENTRIES) begin
                    res.status = ST_FULL;
                end else begin
                    stored_entries[stored_count].row   = row;
                    stored_entries[stored_count].col   = col;
                    stored_entries[stored_count].value = value;
                    stored_count++;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // watch both streams and the configuration port
    always @(posedge aclk) begin
        if (!aresetn) begin
            row_limit    = DIM_RESET;
            col_limit    = DIM_RESET;
            stored_count = 0;
            pending_results.delete();
        end else begin
            // register write
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_ROW_COUNT) begin
                    row_limit = pwdata[DIM_W-1:0];
                end else begin
                    col_limit = pwdata[DIM_W-1:0];
                end
            end
            // result transaction against the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual value_out %h status %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    error_total++;
                end else begin
                    oldest = pending_results.pop_front();
                    if (oldest.value_out !== m_axis_tdata) begin
                        $display("%0t: value_out mismatch, expected %h actual %h",
                                 $time, oldest.value_out, m_axis_tdata);
                        error_total++;
                    end
                    if (oldest.status !== m_axis_tuser) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, oldest.status, m_axis_tuser);
                        error_total++;
                    end
                end
            end
            // input transaction
            if (s_axis_tvalid && s_axis_tready) begin
                pending_results.push_back(table_outcome(s_axis_tuser, s_axis_tdata[9:0],
                                                        s_axis_tdata[19:10],
                                                        s_axis_tdata[51:20]));
            end
        end
        outstanding <= pending_results.size();
        mismatches  <= error_total;
    end

endmodule

>>> sim/testbench.sv
// testbench top for the sparse coordinate table: clock, reset, stimulus and verdict
module testbench;
    import sct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [55:0]           s_axis_tdata;   // row_index, column_index, value_in, pad
    logic [1:0]            s_axis_tuser;   // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;   // value_out
    logic [1:0]            m_axis_tuser;   // status
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    int                    mismatches;
    int                    outstanding;

    // stimulus shaping state
    bit                    no_idle = 1'b0;
    int                    sender_calm = 0;
    int                    row_bound = 1024;
    int                    col_bound = 1024;
    int                    phase_rows [7] = '{1024, 2047, 1, 1000, 0, 7, 2047};
    int                    phase_cols [7] = '{1024, 0, 1, 1000, 2047, 3, 2047};

    sparse_coordinate_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sct_result_checker result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // hard limit on run time
    initial begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stall bursts, quiet stretches and one long hold-off
    initial begin : result_sink
        int stall_left;
        int calm_left;
        int taken;
        bit held;
        stall_left = 0;
        calm_left  = 0;
        taken      = 0;
        held       = 1'b0;
        m_axis_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                taken++;
            end
            if (taken == 60 && !held) begin
                // long hold-off so the block backs up and stalls its input
                held       = 1'b1;
                stall_left = 400;
            end else if (stall_left == 0 && calm_left == 0 && !no_idle) begin
                if ($urandom_range(0, 99) < 12) begin
                    stall_left = $urandom_range(1, 17);
                end else if ($urandom_range(0, 99) < 4) begin
                    calm_left = $urandom_range(20, 80);
                end
            end
            if (calm_left > 0) begin
                calm_left--;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // pick an operation code, no-op now and then
    function automatic logic [1:0] pick_operation();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return OP_NOP;
        if (roll < 4) return OP_SET;
        if (roll < 7) return OP_GET;
        return OP_ACC;
    endfunction

    // pick a value: small signed, near either extreme, or anything
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 16)) - 32'd8;
            1: return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
            2: return 32'h8000_0000 + 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    // offer one transaction, with an optional idle gap first
    task automatic send_operation(input logic [1:0] op, input logic [9:0] row,
                                  input logic [9:0] col, input logic [31:0] value);
        if (!no_idle) begin
            if (sender_calm > 0) begin
                sender_calm--;
            end else if ($urandom_range(0, 99) < 25) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else if ($urandom_range(0, 99) < 5) begin
                sender_calm = $urandom_range(10, 40);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, value, col, row};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // stop offering and wait until every result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // one register write: setup cycle, then access until pready
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // reconfigure both dimensions once the block is idle
    task automatic set_dimensions(input int rows, input int cols);
        drain_results();
        write_register({REG_ROW_COUNT, 2'b00}, 32'(rows));
        write_register({REG_COLUMN_COUNT, 2'b00}, 32'(cols));
        row_bound = rows;
        col_bound = cols;
    endtask

    // random transaction, mostly on a small patch of coordinates so matches are common
    task automatic send_random_item();
        int         sel;
        int         n;
        logic [9:0] row;
        logic [9:0] col;
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            row = 10'($urandom_range(0, 5));
            col = 10'($urandom_range(0, 5));
        end else if (sel < 92) begin
            row = 10'($urandom);
            col = 10'($urandom);
        end else begin
            // just inside or just on the configured bounds
            n   = (row_bound == 0) ? 0 : row_bound - int'($urandom_range(0, 1));
            row = (n > 1023) ? 10'd1023 : 10'(n);
            n   = (col_bound == 0) ? 0 : col_bound - int'($urandom_range(0, 1));
            col = (n > 1023) ? 10'd1023 : 10'(n);
        end
        send_operation(pick_operation(), row, col, pick_value());
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int n;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_NOP;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, extremes, overflow wrap, overwrite, no-op
        send_operation(OP_GET, 10'd0, 10'd0, 32'd0);
        send_operation(OP_SET, 10'd0, 10'd0, 32'h7FFF_FFFF);
        send_operation(OP_GET, 10'd0, 10'd0, 32'hFFFF_FFFF);
        send_operation(OP_ACC, 10'd0, 10'd0, 32'd1);
        send_operation(OP_GET, 10'd0, 10'd0, 32'd0);
        send_operation(OP_ACC, 10'd1023, 10'd1023, 32'h8000_0000);
        send_operation(OP_ACC, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
        send_operation(OP_GET, 10'd1023, 10'd1023, 32'd0);
        send_operation(OP_SET, 10'd1023, 10'd0, 32'hFFFF_FFFB);
        send_operation(OP_SET, 10'd1023, 10'd0, 32'd12345);
        send_operation(OP_GET, 10'd1023, 10'd0, 32'd0);
        send_operation(OP_GET, 10'd0, 10'd1023, 32'd0);
        send_operation(OP_NOP, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
        send_operation(OP_NOP, 10'd0, 10'd0, 32'd0);
        send_operation(OP_SET, 10'd5, 10'd7, 32'd0);
        send_operation(OP_GET, 10'd7, 10'd5, 32'd0);
        send_operation(OP_ACC, 10'd5, 10'd7, 32'h5555_5555);
        send_operation(OP_GET, 10'd5, 10'd7, 32'd0);

        // directed: bounds, index equal to the bound is out of range
        set_dimensions(4, 6);
        send_operation(OP_SET, 10'd4, 10'd0, 32'd9);
        send_operation(OP_GET, 10'd0, 10'd6, 32'd0);
        send_operation(OP_ACC, 10'd3, 10'd5, 32'hAAAA_AAAA);
        send_operation(OP_GET, 10'd3, 10'd5, 32'd0);
        send_operation(OP_NOP, 10'd1023, 10'd1023, 32'd0);

        // directed: zero rows rejects everything
        set_dimensions(0, 6);
        send_operation(OP_GET, 10'd0, 10'd0, 32'd0);

        // random phases over several register settings
        for (int phase = 0; phase < 7; phase++) begin
            set_dimensions(phase_rows[phase], phase_cols[phase]);
            repeat (75) send_random_item();
        end

        // updates, extremes and a mid-run bound change, no idling from here on
        no_idle = 1'b1;
        set_dimensions(1024, 1024);
        send_operation(OP_SET, 10'd777, 10'd778, 32'd1);
        send_operation(OP_ACC, 10'd778, 10'd777, 32'd2);
        send_operation(OP_GET, 10'd777, 10'd778, 32'd0);
        send_operation(OP_GET, 10'd0, 10'd1023, 32'd0);
        send_operation(OP_ACC, 10'd0, 10'd1023, 32'h7FFF_FFFF);
        send_operation(OP_GET, 10'd0, 10'd1023, 32'd0);
        send_operation(OP_SET, 10'd1, 10'd1022, 32'h8000_0000);
        send_operation(OP_NOP, 10'd777, 10'd778, 32'd3);
        set_dimensions(512, 1024);
        send_operation(OP_GET, 10'd600, 10'd5, 32'd0);
        send_operation(OP_SET, 10'd511, 10'd512, 32'd77);
        set_dimensions(1024, 1024);
        repeat (20) begin
            if ($urandom_range(0, 1) == 0) begin
                n = $urandom_range(0, 1023);
                send_operation(pick_operation(), 10'(n), 10'(1023 - n), pick_value());
            end else begin
                send_operation(pick_operation(), 10'($urandom), 10'($urandom), pick_value());
            end
        end

        // wait out the last results, then idle before the verdict
        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/sct_pkg.sv
sv/sct_entry_mem.sv
sv/sct_scan_seq.sv
sv/sparse_coordinate_table.sv
sv/sct_checker.sv
sim/sct_result_checker.sv
sim/testbench.sv
